/* rtl/pfa_pkg.sv */
// Package for the partition fit allocator.
// Holds the transaction structs, the slot record, the codes and the sizing constants.
// It depends on nothing else.
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int unsigned SLOT_COUNT = 16;
    localparam int unsigned SLOT_IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [22:0] MEM_BYTES = 23'd1048576;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        op;
        logic [23:0] owner_id;
        logic [20:0] req_size;
        logic [1:0]  policy;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_index;
        logic [19:0] grant_base;
        logic [4:0]  released_count;
    } t_rsp;

    typedef struct packed {
        logic [19:0] base;
        logic [20:0] size;
        logic [23:0] owner;
    } t_slot;

    typedef struct packed {
        logic                  start;
        logic                  eval;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  is_last;
    } t_fit_ctl;

    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] pick;
        logic [19:0]           best_base;
        logic [SLOT_CNT_W-1:0] count;
        logic [19:0]           last_base;
        logic [20:0]           last_size;
    } t_fit_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END,
        ST_DECIDE
    } t_state;

endpackage

/* rtl/pfa_fit_unit.sv */
// Shared compare unit of the partition fit allocator: judges one slot record per cycle.
// Keeps the running fit choice, the release count and the last made slot's extent.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_fit_unit import pfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fit_ctl i_ctl,
    input  t_req     i_req,
    input  t_slot    i_slot,
    input  logic     i_busy,
    output logic     o_clr,
    output t_fit_res o_res
);

    logic                  r_found;
    logic [SLOT_IDX_W-1:0] r_pick;
    logic [20:0]           r_best_size;
    logic [19:0]           r_best_base;
    logic [SLOT_CNT_W-1:0] r_count;
    logic [19:0]           r_last_base;
    logic [20:0]           r_last_size;

    logic cand;
    logic better;
    logic take;

    always_comb begin
        o_clr  = i_ctl.eval && (i_req.op == OP_RELEASE) && i_busy
                 && (i_slot.owner == i_req.owner_id);
        cand   = !i_busy && (i_slot.size >= i_req.req_size);
        better = !r_found
                 || ((i_req.policy == POL_BEST) && (i_slot.size < r_best_size))
                 || ((i_req.policy == POL_WORST) && (i_slot.size > r_best_size));
        take   = i_ctl.eval && (i_req.op == OP_ALLOC) && cand && better;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
            r_count <= '0;
        end else begin
            if (take) begin
                r_found <= 1'b1;
            end
            if (o_clr) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pick      <= i_ctl.idx;
            r_best_size <= i_slot.size;
            r_best_base <= i_slot.base;
        end
        if (i_ctl.eval && i_ctl.is_last) begin
            r_last_base <= i_slot.base;
            r_last_size <= i_slot.size;
        end
    end

    always_comb begin
        o_res.found     = r_found;
        o_res.pick      = r_pick;
        o_res.best_base = r_best_base;
        o_res.count     = r_count;
        o_res.last_base = r_last_base;
        o_res.last_size = r_last_size;
    end

endmodule

/* rtl/partition_fit_allocator.sv */
// Top level of the partition fit allocator: sequencer, slot store, busy marks, result register.
// Depends on pfa_pkg and pfa_fit_unit.
//
//   Channel   Direction  Handshake                    Payload
//   in        to block   i_in_valid / o_in_stall      i_in_item  (t_req)
//   out       from block o_out_valid / i_out_stall    o_out_item (t_rsp)
//
// A transaction runs from acceptance through a scan of the slots made so far, one slot per
// cycle through the shared compare unit, then an end-address step (ST_END) and a commit step
// (ST_DECIDE) that loads the result register.
// Reset is synchronous and active low; it clears the busy marks, the made count and control.
// A result waiting in the output register does not block the next input transaction; only a
// commit waits for the register to be free.
`timescale 1ns / 1ps

module partition_fit_allocator import pfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_item
);

    t_state r_state;
    t_state n_state;

    t_req                  r_req;
    logic [SLOT_CNT_W-1:0] r_made;
    logic [SLOT_CNT_W-1:0] r_idx;
    logic                  r_pend;
    logic [SLOT_IDX_W-1:0] r_pidx;
    logic [SLOT_COUNT-1:0] r_busy;
    logic [21:0]           r_end;
    t_slot                 r_rd;
    logic                  r_out_valid;
    t_rsp                  r_out;

    t_slot mem [SLOT_COUNT];

    logic                  accept;
    logic                  issue;
    logic                  can_load;
    logic                  commit;
    logic                  wr_en;
    logic                  grow;
    logic [SLOT_IDX_W-1:0] wr_addr;
    t_slot                 wr_data;
    t_rsp                  rsp;
    logic                  append_ok;
    logic [22:0]           end_sum;
    t_fit_ctl              fit_ctl;
    t_fit_res              fit_res;
    logic                  fit_clr;
    logic [SLOT_COUNT-1:0] made_mask;

    assign accept   = i_in_valid && !o_in_stall;
    assign issue    = (r_state == ST_SCAN) && (r_idx < r_made);
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        commit          = (r_state == ST_DECIDE) && can_load;
        fit_ctl.start   = accept;
        fit_ctl.eval    = r_pend;
        fit_ctl.idx     = r_pidx;
        fit_ctl.is_last = ({1'b0, r_pidx} == (r_made - 1'b1));

        end_sum   = {1'b0, r_end} + {2'b00, r_req.req_size};
        append_ok = (r_made < SLOT_CNT_W'(SLOT_COUNT)) && (end_sum <= MEM_BYTES);

        rsp     = '0;
        wr_en   = 1'b0;
        grow    = 1'b0;
        wr_addr = fit_res.pick;
        wr_data = '{base: fit_res.best_base, size: r_req.req_size, owner: r_req.owner_id};

        if (r_req.op == OP_RELEASE) begin
            rsp.status         = (fit_res.count == '0) ? STAT_NOT_FOUND : STAT_DONE;
            rsp.released_count = fit_res.count;
        end else if (r_req.req_size == '0) begin
            rsp.status = STAT_FULL;
        end else if (fit_res.found) begin
            rsp.status     = STAT_DONE;
            rsp.slot_index = fit_res.pick;
            rsp.grant_base = fit_res.best_base;
            wr_en          = commit;
        end else if (append_ok) begin
            rsp.status     = STAT_DONE;
            rsp.slot_index = r_made[SLOT_IDX_W-1:0];
            rsp.grant_base = r_end[19:0];
            wr_addr        = r_made[SLOT_IDX_W-1:0];
            wr_data.base   = r_end[19:0];
            wr_en          = commit;
            grow           = commit;
        end else begin
            rsp.status = STAT_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_made      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (accept) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (fit_clr) begin
                r_busy[r_pidx] <= 1'b0;
            end
            if (wr_en) begin
                r_busy[wr_addr] <= 1'b1;
            end
            if (grow) begin
                r_made <= r_made + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
        if (issue) begin
            r_pidx <= r_idx[SLOT_IDX_W-1:0];
        end
        if (r_state == ST_END) begin
            r_end <= (r_made == '0) ? '0
                     : ({2'b00, fit_res.last_base} + {1'b0, fit_res.last_size});
        end
        if (commit) begin
            r_out <= rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[r_idx[SLOT_IDX_W-1:0]];
    end

    pfa_fit_unit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_req   (r_req),
        .i_slot  (r_rd),
        .i_busy  (r_busy[r_pidx]),
        .o_clr   (fit_clr),
        .o_res   (fit_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            made_mask[i] = (SLOT_CNT_W'(i) < r_made);
        end
    end

    // The made count never passes the size of the table.
    a_made_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_made <= SLOT_CNT_W'(SLOT_COUNT))
        else $error("made count beyond slot table");

    // Only made slots can ever be busy.
    a_busy_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy & ~made_mask) == '0)
        else $error("busy mark on a slot that was never made");

    // A slot under evaluation belongs to the scan and lies within the made slots.
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == ST_SCAN) && ({1'b0, r_pidx} < r_made)))
        else $error("slot evaluated outside the scan");

    // A commit always leaves a result in the output register.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed transaction left no result");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the partition fit allocator, with directed and random traffic.
// Depends on pfa_pkg and partition_fit_allocator; the expected replies come from a
// behavioural copy of the slot table kept here.
`timescale 1ns / 1ps

module testbench import pfa_pkg::*; ();

    localparam logic [1:0]  POL_SPARE      = 2'd3;
    localparam int          POOL_SIZE      = 6;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [23:0] OWN_A          = 24'h414141;
    localparam logic [23:0] OWN_B          = 24'h424242;
    localparam logic [23:0] OWN_C          = 24'h434343;
    localparam logic [23:0] OWN_D          = 24'h444444;
    localparam logic [23:0] OWN_E          = 24'h454545;
    localparam logic [23:0] OWN_F          = 24'h464646;
    localparam logic [23:0] OWN_FILL       = 24'hA5A5A5;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_req in_item   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_item;

    // Shadow copy of the slot table.
    logic [19:0] part_base  [SLOT_COUNT];
    logic [20:0] part_size  [SLOT_COUNT];
    logic [23:0] part_owner [SLOT_COUNT];
    logic        part_busy  [SLOT_COUNT];
    int          parts_made = 0;

    t_rsp        owed_replies [$];
    logic [23:0] owner_pool [POOL_SIZE];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;

    partition_fit_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            part_busy[i] = 1'b0;
        end
    end

    function automatic t_rsp next_reply(t_req r);
        t_rsp        rsp;
        logic        found;
        int          pick;
        int          cnt;
        logic [22:0] end_addr;
        rsp = '0;
        if (r.op == OP_RELEASE) begin
            cnt = 0;
            for (int i = 0; i < parts_made; i++) begin
                if (part_busy[i] && part_owner[i] == r.owner_id) begin
                    part_busy[i] = 1'b0;
                    cnt++;
                end
            end
            rsp.status = (cnt == 0) ? STAT_NOT_FOUND : STAT_DONE;
            rsp.released_count = 5'(cnt);
            return rsp;
        end
        if (r.req_size == '0) begin
            rsp.status = STAT_FULL;
            return rsp;
        end
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < parts_made; i++) begin
            if (!part_busy[i] && part_size[i] >= r.req_size) begin
                if (!found) begin
                    found = 1'b1;
                    pick = i;
                end else if (r.policy == POL_BEST && part_size[i] < part_size[pick]) begin
                    pick = i;
                end else if (r.policy == POL_WORST && part_size[i] > part_size[pick]) begin
                    pick = i;
                end
            end
        end
        if (found) begin
            part_size[pick]  = r.req_size;
            part_owner[pick] = r.owner_id;
            part_busy[pick]  = 1'b1;
            rsp.status = STAT_DONE;
            rsp.slot_index = 4'(pick);
            rsp.grant_base = part_base[pick];
            return rsp;
        end
        if (parts_made >= SLOT_COUNT) begin
            rsp.status = STAT_FULL;
            return rsp;
        end
        end_addr = '0;
        if (parts_made > 0) begin
            end_addr = 23'(part_base[parts_made - 1]) + 23'(part_size[parts_made - 1]);
        end
        if (end_addr + 23'(r.req_size) > MEM_BYTES) begin
            rsp.status = STAT_FULL;
            return rsp;
        end
        part_base[parts_made]  = end_addr[19:0];
        part_size[parts_made]  = r.req_size;
        part_owner[parts_made] = r.owner_id;
        part_busy[parts_made]  = 1'b1;
        rsp.status = STAT_DONE;
        rsp.slot_index = 4'(parts_made);
        rsp.grant_base = end_addr[19:0];
        parts_made++;
        return rsp;
    endfunction

    function automatic t_req make_req(logic op, logic [23:0] who, logic [20:0] size,
                                      logic [1:0] pol);
        t_req r;
        r.op = op;
        r.owner_id = who;
        r.req_size = size;
        r.policy = pol;
        return r;
    endfunction

    function automatic logic [20:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 72) begin
            return 21'($urandom_range(4096, 1));
        end else if (roll < 98) begin
            return 21'($urandom_range(65535, 1));
        end
        return 21'($urandom_range(1048576, 1));
    endfunction

    // Entered and left at a falling edge; valid stays high into the next call unless a gap is
    // drawn, so that it is never lowered and raised in the same step.
    task automatic send_item(input t_req r, output t_rsp want);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item <= r;
        do begin
            @(posedge clk);
        end while (in_stall);
        want = next_reply(r);
        owed_replies.push_back(want);
        @(negedge clk);
    endtask

    task automatic sender_pause();
        in_valid <= 1'b0;
        while (owed_replies.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic report_mismatch(string why, t_rsp want, t_rsp got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): expected status %0d slot %0d base %h count %0d,",
                     why, want.status, want.slot_index, want.grant_base, want.released_count);
            $display("    got status %0d slot %0d base %h count %0d",
                     got.status, got.slot_index, got.grant_base, got.released_count);
        end
    endtask

    always @(posedge clk) begin : check_replies
        t_rsp want;
        t_rsp got;
        if (rst_n && out_valid && !out_stall) begin
            got = out_item;
            if (owed_replies.size() == 0) begin
                report_mismatch("no transaction outstanding", '0, got);
            end else begin
                want = owed_replies.pop_front();
                if (got.status !== want.status || got.slot_index !== want.slot_index ||
                    got.grant_base !== want.grant_base ||
                    got.released_count !== want.released_count) begin
                    report_mismatch("wrong reply", want, got);
                end
            end
        end
    end

    initial begin : drive_out_stall
        int held;
        held = 0;
        forever begin
            @(negedge clk);
            if (hold_req && held == 0) begin
                hold_req = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held > 0) begin
                held--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 15);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[partition_fit_allocator] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_empty_table();
        t_rsp got;
        send_item(make_req(OP_RELEASE, 24'h000000, 21'd5, POL_FIRST), got);
        send_item(make_req(OP_ALLOC, 24'hFFFFFF, 21'd0, POL_BEST), got);
    endtask

    task automatic test_whole_memory();
        t_rsp got;
        send_item(make_req(OP_ALLOC, 24'hFFFFFF, 21'd1048576, POL_FIRST), got);
        send_item(make_req(OP_ALLOC, 24'h000000, 21'd1, POL_BEST), got);
        send_item(make_req(OP_ALLOC, 24'h000000, 21'h1FFFFF, POL_WORST), got);
        send_item(make_req(OP_RELEASE, 24'hFFFFFF, 21'h1FFFFF, POL_SPARE), got);
        send_item(make_req(OP_ALLOC, OWN_A, 21'd16, POL_SPARE), got);
    endtask

    task automatic test_fit_policies();
        t_rsp got;
        send_item(make_req(OP_ALLOC, OWN_B, 21'd100, POL_FIRST), got);
        send_item(make_req(OP_ALLOC, OWN_C, 21'd50, POL_BEST), got);
        send_item(make_req(OP_ALLOC, OWN_B, 21'd200, POL_WORST), got);
        send_item(make_req(OP_ALLOC, OWN_C, 21'd80, POL_FIRST), got);
        send_item(make_req(OP_RELEASE, OWN_B, 21'd0, POL_FIRST), got);
        send_item(make_req(OP_RELEASE, OWN_C, 21'd0, POL_FIRST), got);
        send_item(make_req(OP_ALLOC, OWN_D, 21'd60, POL_BEST), got);
        send_item(make_req(OP_ALLOC, OWN_E, 21'd60, POL_WORST), got);
        send_item(make_req(OP_ALLOC, OWN_F, 21'd60, POL_FIRST), got);
        send_item(make_req(OP_ALLOC, OWN_D, 21'd60, POL_FIRST), got);
        send_item(make_req(OP_RELEASE, OWN_D, 21'd0, POL_FIRST), got);
        send_item(make_req(OP_RELEASE, OWN_E, 21'd0, POL_FIRST), got);
        send_item(make_req(OP_RELEASE, OWN_F, 21'd0, POL_FIRST), got);
    endtask

    task automatic send_pool_item();
        t_rsp        got;
        logic [23:0] who;
        who = owner_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(99) < 65) begin
            send_item(make_req(OP_ALLOC, who, pick_size(), 2'($urandom)), got);
        end else begin
            send_item(make_req(OP_RELEASE, who, 21'($urandom), 2'($urandom)), got);
        end
    endtask

    task automatic test_random(int n);
        t_rsp got;
        int   roll;
        int   slot;
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3) && (k < n / 3 + 100);
            if ($urandom_range(39) == 0) begin
                slot = $urandom_range(POOL_SIZE - 1);
                send_item(make_req(OP_RELEASE, owner_pool[slot], 21'($urandom),
                                   2'($urandom)), got);
                owner_pool[slot] = 24'($urandom);
            end
            roll = $urandom_range(99);
            if (roll < 86) begin
                send_pool_item();
            end else if (roll < 92) begin
                send_item(make_req(OP_RELEASE, 24'($urandom), 21'($urandom), 2'($urandom)),
                          got);
            end else if (roll < 96) begin
                send_item(make_req(OP_ALLOC, 24'($urandom), 21'd0, 2'($urandom)), got);
            end else begin
                send_item(make_req(OP_ALLOC, 24'($urandom),
                                   21'($urandom_range(2097151, 1048577)), 2'($urandom)), got);
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
            send_pool_item();
        end
        calm = 1'b0;
        sender_pause();
    endtask

    task automatic test_table_full();
        t_rsp got;
        int   tries;
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_item(make_req(OP_RELEASE, owner_pool[i], 21'($urandom), 2'($urandom)), got);
        end
        tries = 0;
        do begin
            send_item(make_req(OP_ALLOC, OWN_FILL, 21'd1, 2'($urandom)), got);
            tries++;
        end while (got.status == STAT_DONE && tries < SLOT_COUNT + 4);
        send_item(make_req(OP_RELEASE, OWN_FILL, 21'h1FFFFF, POL_SPARE), got);
    endtask

    initial begin : run_tests
        owner_pool[0] = 24'h000000;
        owner_pool[1] = 24'hFFFFFF;
        owner_pool[2] = OWN_A;
        for (int i = 3; i < POOL_SIZE; i++) begin
            owner_pool[i] = 24'($urandom);
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_whole_memory();
        test_fit_policies();
        test_random(300);
        test_backpressure();
        test_random(300);
        test_table_full();
        sender_pause();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && owed_replies.size() == 0) begin
            $display("[partition_fit_allocator] OK");
        end else begin
            $display("[partition_fit_allocator] ERROR");
        end
        $finish;
    end

endmodule
